[hdl/trs_pkg.sv]
// Shared types, constants and the arctangent table for the TRS model matrix block.
package trs_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_pose;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m03;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
    } t_mtx;

    // quadrant and residual angle in radians, Q30
    typedef struct packed {
        logic [1:0]         quad;
        logic signed [32:0] z;
    } t_ang;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_trig;

    localparam logic signed [16:0] TURN_UNITS    = 17'sd23040;
    localparam logic [14:0]        QUARTER_UNITS = 15'd5760;
    localparam logic [14:0]        HALF_UNITS    = 15'd11520;
    localparam logic [14:0]        THREEQ_UNITS  = 15'd17280;
    // r*PI_Q30/11520 = r*RAD_INT + r*RAD_REM/11520
    localparam logic [18:0]        RAD_INT       = 19'd292817;
    localparam logic [12:0]        RAD_REM       = 13'd7586;
    // ceil(2^24/45), exact quotient for 18-bit dividends
    localparam logic [18:0]        RECIP_45      = 19'd372828;
    localparam logic signed [33:0] CORDIC_X0     = 34'sd652032874;

    function automatic logic signed [32:0] f_atan(input int i);
        logic signed [32:0] v;
        case (i)
            0:       v = 33'sd843314856;
            1:       v = 33'sd497837829;
            2:       v = 33'sd263043836;
            3:       v = 33'sd133525158;
            4:       v = 33'sd67021686;
            5:       v = 33'sd33543515;
            6:       v = 33'sd16775850;
            7:       v = 33'sd8388437;
            8:       v = 33'sd4194282;
            9:       v = 33'sd2097149;
            10:      v = 33'sd1048575;
            11:      v = 33'sd524287;
            12:      v = 33'sd262143;
            13:      v = 33'sd131071;
            14:      v = 33'sd65535;
            15:      v = 33'sd32767;
            16:      v = 33'sd16383;
            17:      v = 33'sd8191;
            18:      v = 33'sd4095;
            19:      v = 33'sd2047;
            20:      v = 33'sd1023;
            21:      v = 33'sd511;
            22:      v = 33'sd255;
            default: v = 33'sd127;
        endcase
        return v;
    endfunction

endpackage

[hdl/trs_angle.sv]
// Angle wrap, quadrant split and conversion to Q30 radians, four stages.
module trs_angle (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output trs_pkg::t_ang      o_ang
);
    import trs_pkg::*;

    logic signed [16:0] v0, v1, v2, v3;
    logic [14:0]        a;
    logic [1:0]         n_q;
    logic [14:0]        n_r;

    logic [1:0]  r_q1, r_q2, r_q3;
    logic [12:0] r_r1;
    logic [30:0] r_hi2, r_hi3;
    logic [25:0] r_t2;
    logic [36:0] r_m3;
    t_ang        r_ang;

    always_comb begin
        v0 = 17'(i_angle);
        v1 = (v0 < 0) ? v0 + TURN_UNITS : v0;
        v2 = (v1 < 0) ? v1 + TURN_UNITS : v1;
        v3 = (v2 >= TURN_UNITS) ? v2 - TURN_UNITS : v2;
        a  = v3[14:0];
        if (a >= THREEQ_UNITS) begin
            n_q = 2'd3;
            n_r = a - THREEQ_UNITS;
        end else if (a >= HALF_UNITS) begin
            n_q = 2'd2;
            n_r = a - HALF_UNITS;
        end else if (a >= QUARTER_UNITS) begin
            n_q = 2'd1;
            n_r = a - QUARTER_UNITS;
        end else begin
            n_q = 2'd0;
            n_r = a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1  <= n_q;
            r_r1  <= n_r[12:0];
            r_q2  <= r_q1;
            r_hi2 <= 31'(32'(r_r1) * 32'(RAD_INT));
            r_t2  <= 26'(r_r1) * 26'(RAD_REM);
            r_q3  <= r_q2;
            r_hi3 <= r_hi2;
            r_m3  <= 37'(r_t2[25:8]) * 37'(RECIP_45);
            r_ang.quad <= r_q3;
            r_ang.z    <= 33'(r_hi3 + 31'(r_m3[36:24]));
        end
    end

    assign o_ang = r_ang;
endmodule

[hdl/trs_cordic.sv]
// Pipelined rotation-mode CORDIC with quadrant fold, one iteration per stage.
module trs_cordic #(
    parameter int TRIG_STAGES = 18
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  trs_pkg::t_ang  i_ang,
    output trs_pkg::t_trig o_trig
);
    import trs_pkg::*;

    logic signed [33:0] r_x [TRIG_STAGES];
    logic signed [33:0] r_y [TRIG_STAGES];
    logic signed [32:0] r_z [TRIG_STAGES];
    logic [1:0]         r_q [TRIG_STAGES];
    t_trig              r_trig;
    logic signed [31:0] fx, fy;

    for (genvar gi = 0; gi < TRIG_STAGES; gi++) begin : g_stage
        logic signed [33:0] px, py;
        logic signed [32:0] pz;
        logic [1:0]         pq;
        if (gi == 0) begin : g_first
            assign px = CORDIC_X0;
            assign py = '0;
            assign pz = i_ang.z;
            assign pq = i_ang.quad;
        end else begin : g_next
            assign px = r_x[gi-1];
            assign py = r_y[gi-1];
            assign pz = r_z[gi-1];
            assign pq = r_q[gi-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[gi] <= pq;
                if (!pz[32]) begin
                    r_x[gi] <= px - (py >>> gi);
                    r_y[gi] <= py + (px >>> gi);
                    r_z[gi] <= pz - f_atan(gi);
                end else begin
                    r_x[gi] <= px + (py >>> gi);
                    r_y[gi] <= py - (px >>> gi);
                    r_z[gi] <= pz + f_atan(gi);
                end
            end
        end
    end

    assign fx = r_x[TRIG_STAGES-1][31:0];
    assign fy = r_y[TRIG_STAGES-1][31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[TRIG_STAGES-1])
                2'd0: begin
                    r_trig.c <= fx;
                    r_trig.s <= fy;
                end
                2'd1: begin
                    r_trig.c <= -fy;
                    r_trig.s <= fx;
                end
                2'd2: begin
                    r_trig.c <= -fx;
                    r_trig.s <= -fy;
                end
                default: begin
                    r_trig.c <= fy;
                    r_trig.s <= -fx;
                end
            endcase
        end
    end

    assign o_trig = r_trig;
endmodule

[hdl/trs_mat.sv]
// Rotation coefficient products, column scaling and saturation, five stages.
module trs_mat (
    input  logic           i_clk,
    input  logic           i_en,
    input  trs_pkg::t_trig i_tx,
    input  trs_pkg::t_trig i_ty,
    input  trs_pkg::t_trig i_tz,
    input  trs_pkg::t_pose i_pose,
    output trs_pkg::t_mtx  o_mtx
);
    import trs_pkg::*;

    function automatic logic signed [31:0] f_mq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [64:0] p);
        logic signed [64:0] t;
        logic signed [34:0] v;
        t = p + 65'sd536870912;
        v = t[64:30];
        if (v > 35'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic signed [31:0] r_zxs, r_zxc, r_czcy, r_czsy, r_szcy, r_czcx;
    logic signed [31:0] r_szsy, r_szcx, r_cxsy, r_cxcy, r_sx1, r_sy1, r_cy1;
    logic signed [31:0] r_czcy2, r_czsy2, r_szcy2, r_czcx2, r_szsy2;
    logic signed [31:0] r_szcx2, r_cxsy2, r_cxcy2, r_sx2;
    logic signed [31:0] r_ssy, r_scy, r_csy, r_ccy;
    logic signed [32:0] r_c [9];
    logic signed [64:0] r_p [9];
    logic signed [31:0] r_px, r_py, r_pz;
    t_mtx               r_mtx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zxs  <= f_mq(i_tz.s, i_tx.s);
            r_zxc  <= f_mq(i_tz.c, i_tx.s);
            r_czcy <= f_mq(i_tz.c, i_ty.c);
            r_czsy <= f_mq(i_tz.c, i_ty.s);
            r_szcy <= f_mq(i_tz.s, i_ty.c);
            r_czcx <= f_mq(i_tz.c, i_tx.c);
            r_szsy <= f_mq(i_tz.s, i_ty.s);
            r_szcx <= f_mq(i_tz.s, i_tx.c);
            r_cxsy <= f_mq(i_tx.c, i_ty.s);
            r_cxcy <= f_mq(i_tx.c, i_ty.c);
            r_sx1  <= i_tx.s;
            r_sy1  <= i_ty.s;
            r_cy1  <= i_ty.c;

            r_ssy   <= f_mq(r_zxs, r_sy1);
            r_scy   <= f_mq(r_zxs, r_cy1);
            r_csy   <= f_mq(r_zxc, r_sy1);
            r_ccy   <= f_mq(r_zxc, r_cy1);
            r_czcy2 <= r_czcy;
            r_czsy2 <= r_czsy;
            r_szcy2 <= r_szcy;
            r_czcx2 <= r_czcx;
            r_szsy2 <= r_szsy;
            r_szcx2 <= r_szcx;
            r_cxsy2 <= r_cxsy;
            r_cxcy2 <= r_cxcy;
            r_sx2   <= r_sx1;

            r_c[0] <= 33'(r_czcy2) - 33'(r_ssy);
            r_c[1] <= -33'(r_szcx2);
            r_c[2] <= 33'(r_czsy2) + 33'(r_scy);
            r_c[3] <= 33'(r_szcy2) + 33'(r_csy);
            r_c[4] <= 33'(r_czcx2);
            r_c[5] <= 33'(r_szsy2) - 33'(r_ccy);
            r_c[6] <= -33'(r_cxsy2);
            r_c[7] <= 33'(r_sx2);
            r_c[8] <= 33'(r_cxcy2);

            for (int k = 0; k < 3; k++) begin
                r_p[3*k]   <= 65'(r_c[3*k])   * 65'(i_pose.scale_x);
                r_p[3*k+1] <= 65'(r_c[3*k+1]) * 65'(i_pose.scale_y);
                r_p[3*k+2] <= 65'(r_c[3*k+2]) * 65'(i_pose.scale_z);
            end
            r_px <= i_pose.pos_x;
            r_py <= i_pose.pos_y;
            r_pz <= i_pose.pos_z;

            r_mtx.m00 <= f_sat(r_p[0]);
            r_mtx.m01 <= f_sat(r_p[1]);
            r_mtx.m02 <= f_sat(r_p[2]);
            r_mtx.m03 <= r_px;
            r_mtx.m10 <= f_sat(r_p[3]);
            r_mtx.m11 <= f_sat(r_p[4]);
            r_mtx.m12 <= f_sat(r_p[5]);
            r_mtx.m13 <= r_py;
            r_mtx.m20 <= f_sat(r_p[6]);
            r_mtx.m21 <= f_sat(r_p[7]);
            r_mtx.m22 <= f_sat(r_p[8]);
            r_mtx.m23 <= r_pz;
        end
    end

    assign o_mtx = r_mtx;
endmodule

[hdl/trs_model_matrix.sv]
// Top level: pose in, upper 3x4 TRS model matrix (Z-X-Y Euler order) out.
//
// Input channel: i_valid / o_ready with the pose struct i_pose (position,
// angles in 1/64 degree, scales, Q16.16). Output channel: o_valid / i_ready
// with the 3x4 matrix o_mtx, Q16.16, rotation entries saturated.
// A transfer happens on a rising edge with valid and ready both high.
//
// The pipeline runs angle wrap and radian conversion, then TRIG_STAGES
// CORDIC iterations plus a quadrant fold, then the coefficient products,
// column scaling and saturation. Throughput is one pose per cycle while
// the output is not stalled; every stage is one register deep.
//
// The pipeline advances while the output register is empty or being
// taken; when the receiver holds i_ready low with a result waiting, every
// stage holds and o_ready drops, so nothing is lost or repeated. Reset
// clears only the valid bits.
module trs_model_matrix #(
    parameter int TRIG_STAGES = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  trs_pkg::t_pose i_pose,
    output logic           o_valid,
    input  logic           i_ready,
    output trs_pkg::t_mtx  o_mtx
);
    import trs_pkg::*;

    localparam int LAT = TRIG_STAGES + 10;
    localparam int DLY = TRIG_STAGES + 8;

    logic          en;
    logic [LAT-1:0] r_vld;
    t_pose         r_dly [DLY];
    t_ang          ang_x, ang_y, ang_z;
    t_trig         trig_x, trig_y, trig_z;

    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= i_pose;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    trs_angle u_ang_x (.i_clk(i_clk), .i_en(en), .i_angle(i_pose.angle_x), .o_ang(ang_x));
    trs_angle u_ang_y (.i_clk(i_clk), .i_en(en), .i_angle(i_pose.angle_y), .o_ang(ang_y));
    trs_angle u_ang_z (.i_clk(i_clk), .i_en(en), .i_angle(i_pose.angle_z), .o_ang(ang_z));

    trs_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cor_x (
        .i_clk(i_clk), .i_en(en), .i_ang(ang_x), .o_trig(trig_x)
    );
    trs_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cor_y (
        .i_clk(i_clk), .i_en(en), .i_ang(ang_y), .o_trig(trig_y)
    );
    trs_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cor_z (
        .i_clk(i_clk), .i_en(en), .i_ang(ang_z), .o_trig(trig_z)
    );

    trs_mat u_mat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_tx  (trig_x),
        .i_ty  (trig_y),
        .i_tz  (trig_z),
        .i_pose(r_dly[DLY-1]),
        .o_mtx (o_mtx)
    );
endmodule
